@@ hdl/raid5_read_with_reconstruct_defines.svh @@
// ---------------------------------------------------------------------------
// RAID5 read engine - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RAID5_READ_WITH_RECONSTRUCT_DEFINES_SVH
`define RAID5_READ_WITH_RECONSTRUCT_DEFINES_SVH

// same-cycle implication
`define RWR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rwr_pkg.sv @@
// ---------------------------------------------------------------------------
// RAID5 read engine - package
// Field widths, register indexes and codes shared by the RTL.
// ---------------------------------------------------------------------------
package rwr_pkg;

    localparam int DATA_W  = 32;   // one block word
    localparam int LB_W    = 14;   // logical block number
    localparam int DVS_W   = 16;   // divisor: (n-1)*s fits in 16 bits
    localparam int ND_W    = 5;    // num_disks register
    localparam int SB_W    = 11;   // stripe_blocks register
    localparam int MASK_W  = 16;   // present_mask register
    localparam int LEN_W   = 11;   // disk_len_words register
    localparam int BLK_W   = LB_W + SB_W;  // level*s + offset
    localparam int CFG_W   = 16;   // config write data
    localparam int CFGI_W  = 2;    // config index

    typedef enum logic [CFGI_W-1:0] {
        CFG_NUM_DISKS     = 2'd0,
        CFG_STRIPE_BLOCKS = 2'd1,
        CFG_PRESENT_MASK  = 2'd2,
        CFG_DISK_LEN      = 2'd3
    } cfg_idx_t;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_READ   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

@@ hdl/rwr_div.sv @@
// ---------------------------------------------------------------------------
// RAID5 read engine - shared divider
// Restoring divider, one quotient bit per cycle; done pulses once results
// are in the registers.
// ---------------------------------------------------------------------------
module rwr_div
    import rwr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [LB_W-1:0]  dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [LB_W-1:0]  quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(LB_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LB_W-1:0]  quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[LB_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[LB_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/rwr_store.sv @@
// ---------------------------------------------------------------------------
// RAID5 read engine - disk block store
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module rwr_store
    import rwr_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/raid5_read_with_reconstruct.sv @@
// Sequence: a load beat, or a read that fails on configuration, goes straight to
//   the done state; other reads run the three divider passes, map and check, then
//   a direct read drains its store word and a rebuilt read walks the disks first.
// Throughput: one item at a time; the three passes of the 14-step shared divider
//   and the one-word-per-cycle store read port set the read time.
// Reset: configuration returns to 2 disks, strip 1, all present, length 0; the
//   block store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// RAID5 read engine with single-disk XOR reconstruction
// Loads words into a block store laid out per disk and serves logical block reads over
// a left-symmetric layout, rebuilding from parity when one disk is missing.
// ---------------------------------------------------------------------------
`include "raid5_read_with_reconstruct_defines.svh"

module raid5_read_with_reconstruct
    import rwr_pkg::*;
#(
    parameter int MAX_DISKS       = 16,
    parameter int BLOCKS_PER_DISK = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [3:0]        disk_index,
    input  logic [9:0]        word_index,
    input  logic [DATA_W-1:0] word_data,
    input  logic [LB_W-1:0]   logical_block,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              status
);

    localparam int DEPTH  = MAX_DISKS * BLOCKS_PER_DISK;
    localparam int ADDR_W = $clog2(DEPTH);

    // Sequencer: three divider passes (r/span, (r mod span)/s, level/n),
    // a mapping step, a check step, then the store read or the XOR walk.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_DIV3,
        S_MAP,
        S_CHK,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [ND_W-1:0]   num_disks_reg;
    logic [SB_W-1:0]   stripe_blocks_reg;
    logic [MASK_W-1:0] present_mask_reg;
    logic [LEN_W-1:0]  disk_len_reg;

    // result and output registers
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              status_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic              res_status_reg;

    // datapath registers
    logic [LB_W-1:0]   level_reg;
    logic [ND_W-1:0]   strip_reg;
    logic [SB_W-1:0]   off_reg;
    logic [ND_W-1:0]   parity_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [ND_W-1:0]   disk_reg;
    logic              one_missing_reg;
    logic [ND_W-1:0]   walk_reg;
    logic              pend_reg;
    logic [DATA_W-1:0] acc_reg;

    // divider hookup
    logic              div_start;
    logic [LB_W-1:0]   div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [LB_W-1:0]   div_quo;
    logic [DVS_W-1:0]  div_rem;

    // store hookup
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              in_accept;
    logic              out_free;
    logic              cfg_bad;
    logic [DVS_W-1:0]  span;
    logic [31:0]       waddr_full;
    logic [31:0]       raddr_full;
    logic [ND_W-1:0]   rd_disk;
    logic [ND_W:0]     disk_sum;
    logic [MASK_W-1:0] live_mask;
    logic [ND_W-1:0]   present_cnt;
    logic              len_fail;
    logic              target_here;
    logic              walk_last;
    logic [DATA_W-1:0] acc_final;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // ---- configuration writes --------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_disks_reg     <= ND_W'(2);
            stripe_blocks_reg <= SB_W'(1);
            present_mask_reg  <= '1;
            disk_len_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_DISKS:     num_disks_reg     <= cfg_data[ND_W-1:0];
                CFG_STRIPE_BLOCKS: stripe_blocks_reg <= cfg_data[SB_W-1:0];
                CFG_PRESENT_MASK:  present_mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_DISK_LEN:      disk_len_reg      <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // ---- read set-up ------------------------------------------------------
    assign cfg_bad = (num_disks_reg < ND_W'(2))
                  || (32'(num_disks_reg) > 32'(MAX_DISKS))
                  || (stripe_blocks_reg == '0);
    // (n-1)*s; n-1 <= 30, so the product stays inside 16 bits
    assign span = DVS_W'(num_disks_reg - 1'b1) * DVS_W'(stripe_blocks_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = logical_block;
        div_dvs   = span;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = in_accept && (func == FUNC_READ) && !cfg_bad;
            end
            S_DIV1:
            begin
                div_start = div_done;
                div_dvd   = div_rem[LB_W-1:0];     // r mod span <= r
                div_dvs   = DVS_W'(stripe_blocks_reg);
            end
            S_DIV2:
            begin
                div_start = div_done;
                div_dvd   = level_reg;
                div_dvs   = DVS_W'(num_disks_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    rwr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---- mapping ----------------------------------------------------------
    // strip + parity + 1 < 2n, so one conditional subtract reduces it mod n
    assign disk_sum = (ND_W+1)'(strip_reg) + (ND_W+1)'(parity_reg) + 1'b1;

    always_comb
    begin
        for (int j = 0; j < MASK_W; j++)
        begin
            live_mask[j] = present_mask_reg[j] && (32'(j) < 32'(num_disks_reg));
        end
    end
    assign present_cnt = ND_W'($countones(live_mask));

    assign len_fail = (32'(blk_reg) >= 32'(disk_len_reg))
                   || (32'(blk_reg) >= 32'(BLOCKS_PER_DISK));
    assign target_here = !disk_reg[ND_W-1] && present_mask_reg[disk_reg[3:0]];
    assign walk_last   = (walk_reg == num_disks_reg - 1'b1);

    // ---- block store ------------------------------------------------------
    assign mem_we     = in_accept && (func == FUNC_LOAD)
                     && (32'(disk_index) < 32'(MAX_DISKS))
                     && (32'(word_index) < 32'(BLOCKS_PER_DISK));
    assign waddr_full = 32'(disk_index) * 32'(BLOCKS_PER_DISK) + 32'(word_index);
    assign mem_waddr  = waddr_full[ADDR_W-1:0];

    assign rd_disk    = (state_reg == S_CHK) ? disk_reg : walk_reg;
    assign mem_re     = ((state_reg == S_CHK) && !len_fail && target_here)
                     || ((state_reg == S_WALK) && (walk_reg != disk_reg));
    assign raddr_full = 32'(rd_disk) * 32'(BLOCKS_PER_DISK) + 32'(blk_reg);
    assign mem_raddr  = raddr_full[ADDR_W-1:0];

    rwr_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (word_data),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign acc_final = pend_reg ? (acc_reg ^ mem_rdata) : acc_reg;

    // ---- datapath registers -----------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV1 && div_done)
        begin
            level_reg <= div_quo;
        end
        if (state_reg == S_DIV2 && div_done)
        begin
            strip_reg <= div_quo[ND_W-1:0];
            off_reg   <= div_rem[SB_W-1:0];
        end
        if (state_reg == S_DIV3 && div_done)
        begin
            parity_reg <= num_disks_reg - 1'b1 - div_rem[ND_W-1:0];
        end
        if (state_reg == S_MAP)
        begin
            blk_reg <= BLK_W'(level_reg) * BLK_W'(stripe_blocks_reg) + BLK_W'(off_reg);
            disk_reg <= (disk_sum >= (ND_W+1)'(num_disks_reg))
                      ? ND_W'(disk_sum - (ND_W+1)'(num_disks_reg))
                      : ND_W'(disk_sum);
            one_missing_reg <= ((ND_W+1)'(present_cnt) + 1'b1)
                             == (ND_W+1)'(num_disks_reg);
            acc_reg <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg ^ mem_rdata;
        end
        if (state_reg == S_CHK)
        begin
            walk_reg <= '0;
        end
        else if (state_reg == S_WALK)
        begin
            walk_reg <= walk_reg + 1'b1;
        end
    end

    // ---- sequencer and output register ------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            read_data_reg  <= '0;
            status_reg     <= STATUS_OK;
            res_data_reg   <= '0;
            res_status_reg <= STATUS_OK;
            pend_reg       <= 1'b0;
        end
        else
        begin
            pend_reg <= mem_re;
            // a new beat loads the output register as the old one leaves
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (func == FUNC_LOAD)
                        begin
                            res_data_reg   <= '0;
                            res_status_reg <= STATUS_OK;
                            state_reg      <= S_DONE;
                        end
                        else if (cfg_bad)
                        begin
                            res_data_reg   <= '0;
                            res_status_reg <= STATUS_FAIL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV3;
                    end
                end
                S_DIV3:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    priority if (len_fail || (!target_here && !one_missing_reg))
                    begin
                        res_data_reg   <= '0;
                        res_status_reg <= STATUS_FAIL;
                        state_reg      <= S_DONE;
                    end
                    else if (target_here)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (walk_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    res_data_reg   <= acc_final;
                    res_status_reg <= STATUS_OK;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        read_data_reg <= res_data_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---- assertions -------------------------------------------------------
    `RWR_ASSERT_NOW(a_store_write_idle, mem_we, state_reg == S_IDLE, "store write while busy")
    `RWR_ASSERT_NOW(a_div_done_state, div_done, (state_reg == S_DIV1) || (state_reg == S_DIV2) || (state_reg == S_DIV3), "divider result with no pass waiting")
    `RWR_ASSERT_NOW(a_pend_state, pend_reg, (state_reg == S_WALK) || (state_reg == S_DRAIN), "read data arrives outside walk")
    `RWR_ASSERT_NOW(a_fail_zero, out_valid && (status == STATUS_FAIL), read_data == '0, "failed read with non-zero data")
    `RWR_ASSERT_NEXT(a_load_done, in_accept && (func == FUNC_LOAD), state_reg == S_DONE, "load beat not completed")

endmodule

@@ bench/raid5_read_with_reconstruct_test.sv @@
// ---------------------------------------------------------------------------
// RAID5 read engine testbench
// Loads disk words and issues logical block reads over several array
// geometries. Replies are checked against typed values or a local model of the layout and
// of the single-disk XOR rebuild, with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module raid5_read_with_reconstruct_test;
    import rwr_pkg::*;

    localparam int HOLD_CYCLES  = 400;       // long receiver hold-off
    localparam int DRAIN_PAUSE  = 4;         // settle time before a register write
    localparam int TAIL_CYCLES  = 100;       // longest read is well under this
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 125;
    localparam int PLAN_ROWS    = 35;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              st;
    } reply_t;

    // one row of the directed part: either a register write or one beat
    typedef struct {
        bit                is_reg;
        cfg_idx_t          reg_idx;
        logic [CFG_W-1:0]  reg_val;
        logic              fn;
        logic [3:0]        dsk;
        logic [9:0]        wrd;
        logic [DATA_W-1:0] dat;
        logic [LB_W-1:0]   lb;
        bit                typed;
        logic [DATA_W-1:0] t_data;
        logic              t_st;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    logic [3:0]        disk_index;
    logic [9:0]        word_index;
    logic [DATA_W-1:0] word_data;
    logic [LB_W-1:0]   logical_block;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] read_data;
    logic              status;

    raid5_read_with_reconstruct dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .disk_index    (disk_index),
        .word_index    (word_index),
        .word_data     (word_data),
        .logical_block (logical_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .status        (status)
    );

    always #10 clk = ~clk;

    // -----------------------------------------------------------------------
    // Local copy of the array: geometry registers, disk words, and a record of
    // which words have been loaded so that no read ever touches a blank entry.
    // -----------------------------------------------------------------------
    logic [ND_W-1:0]   geo_disks;
    logic [SB_W-1:0]   geo_strip;
    logic [MASK_W-1:0] geo_mask;
    logic [LEN_W-1:0]  geo_len;
    logic [DATA_W-1:0] disk_words [16][1024];
    bit                word_loaded [16][1024];

    reply_t      replies_due [$];
    int unsigned faults;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned holds_asked;
    int unsigned holds_done;
    int unsigned cycles;

    // directed rows; expected values typed in only for loads and plain failures
    plan_row_t plan [PLAN_ROWS] = '{
        // straight after reset the disk length is zero: every read fails
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          1, 32'h0, STATUS_FAIL},
        // loads, two of them at the corners of the store, always answer zero, ok
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_LOAD, 4'd0, 10'd0, 32'hFFFF_FFFF, 14'd0,
          1, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_LOAD, 4'd15, 10'd1023, 32'h0, 14'h3FFF,
          1, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_LOAD, 4'd1, 10'd0, 32'h5A5A_5A5A, 14'd0,
          1, 32'h0, STATUS_OK},
        // length beyond the disk size is clipped to it
        '{1, CFG_DISK_LEN, 16'd2047, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd1023,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd1024,
          1, 32'h0, STATUS_FAIL},
        // disk counts outside 2..16 fail every read
        '{1, CFG_NUM_DISKS, 16'd0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        '{1, CFG_NUM_DISKS, 16'd1, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        '{1, CFG_NUM_DISKS, 16'd17, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        // all ones on the write data: only the low five bits land
        '{1, CFG_NUM_DISKS, 16'hFFFF, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        '{1, CFG_NUM_DISKS, 16'd16, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        // zero strip size fails every read
        '{1, CFG_STRIPE_BLOCKS, 16'd0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          1, 32'h0, STATUS_FAIL},
        // widest strip, sixteen disks: top block lands on disk 8
        '{1, CFG_STRIPE_BLOCKS, 16'd2047, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          0, 32'h0, STATUS_OK},
        // disk 8 gone: rebuilt from the other fifteen
        '{1, CFG_PRESENT_MASK, 16'hFEFF, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          0, 32'h0, STATUS_OK},
        // disks 7 and 8 gone: target lost, a present disk still reads
        '{1, CFG_PRESENT_MASK, 16'hFE7F, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          1, 32'h0, STATUS_FAIL},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{1, CFG_PRESENT_MASK, 16'h0000, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          1, 32'h0, STATUS_FAIL},
        // four disks, disk 2 gone, mask bits above the disk count clear:
        // those must be ignored, so the read is rebuilt
        '{1, CFG_NUM_DISKS, 16'd4, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{1, CFG_STRIPE_BLOCKS, 16'd1024, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{1, CFG_PRESENT_MASK, 16'h000B, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd2053,
          0, 32'h0, STATUS_OK},
        // block past the end of the disk
        '{1, CFG_DISK_LEN, 16'd1024, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd0,
          0, 32'h0, STATUS_OK},
        '{0, CFG_NUM_DISKS, 16'h0, FUNC_READ, 4'd0, 10'd0, 32'h0, 14'd16383,
          1, 32'h0, STATUS_FAIL}
    };

    function automatic bit disk_present(input int unsigned d);
        return d < 16 && geo_mask[d];
    endfunction

    function automatic int unsigned disks_absent();
        int unsigned cnt;
        cnt = 0;
        for (int unsigned i = 0; i < geo_disks; i++)
            if (!disk_present(i))
                cnt++;
        return cnt;
    endfunction

    // left-symmetric placement; true when the block is reachable at all
    function automatic bit locate_block(input logic [LB_W-1:0] lb,
                                        output int unsigned dsk,
                                        output int unsigned blk);
        int unsigned n, s, len, rr, span, lvl, par;
        n   = geo_disks;
        s   = geo_strip;
        len = (geo_len > 1024) ? 1024 : geo_len;
        rr  = lb;
        dsk = 0;
        blk = 0;
        if (n < 2 || n > 16 || s == 0)
            return 1'b0;
        span = (n - 1) * s;
        lvl  = rr / span;
        par  = n - 1 - (lvl % n);
        blk  = lvl * s + rr % s;
        dsk  = ((rr % span) / s + par + 1) % n;
        return blk < len;
    endfunction

    // applies one accepted beat to the local array and returns its reply
    function automatic reply_t raid_lookup(input logic fn, input logic [3:0] dsk,
                                           input logic [9:0] wrd,
                                           input logic [DATA_W-1:0] dat,
                                           input logic [LB_W-1:0] lb);
        reply_t      rep;
        int unsigned tgt, blk;
        rep = '{data: '0, st: STATUS_OK};
        if (fn == FUNC_LOAD) begin
            disk_words[dsk][wrd]  = dat;
            word_loaded[dsk][wrd] = 1'b1;
            return rep;
        end
        rep.st = STATUS_FAIL;
        if (!locate_block(lb, tgt, blk))
            return rep;
        if (disk_present(tgt)) begin
            rep.data = disk_words[tgt][blk];
            rep.st   = STATUS_OK;
        end else if (disks_absent() == 1) begin
            for (int unsigned i = 0; i < geo_disks; i++)
                if (i != tgt)
                    rep.data ^= disk_words[i][blk];
            rep.st = STATUS_OK;
        end
        return rep;
    endfunction

    task automatic note_fault(input string what, input reply_t want, input reply_t got);
        faults++;
        if (faults <= REPORT_LIMIT)
            $display("%0t %s: expected data %h status %0d, got data %h status %0d",
                     $realtime, what, want.data, want.st, got.data, got.st);
    endtask

    // one beat on the input channel; valid is left high on return
    task automatic send_item(input logic fn, input logic [3:0] dsk,
                             input logic [9:0] wrd, input logic [DATA_W-1:0] dat,
                             input logic [LB_W-1:0] lb, input bit typed,
                             input reply_t typed_reply);
        reply_t rep;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= fn;
        disk_index    <= dsk;
        word_index    <= wrd;
        word_data     <= dat;
        logical_block <= lb;
        do @(posedge clk); while (in_stall);
        rep = raid_lookup(fn, dsk, wrd, dat, lb);
        replies_due.push_back(typed ? typed_reply : rep);
    endtask

    // loads any word a read would touch that has never been written
    task automatic cover_read(input logic [LB_W-1:0] lb);
        int unsigned tgt, blk;
        if (!locate_block(lb, tgt, blk))
            return;
        if (disk_present(tgt)) begin
            if (!word_loaded[tgt][blk])
                send_item(FUNC_LOAD, 4'(tgt), 10'(blk), $urandom, 14'($urandom), 0, '0);
        end else if (disks_absent() == 1) begin
            for (int unsigned i = 0; i < geo_disks; i++)
                if (i != tgt && !word_loaded[i][blk])
                    send_item(FUNC_LOAD, 4'(i), 10'(blk), $urandom, 14'($urandom), 0, '0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // registers change only with the engine empty
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] raw);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_DISKS:     geo_disks = raw[ND_W-1:0];
            CFG_STRIPE_BLOCKS: geo_strip = raw[SB_W-1:0];
            CFG_PRESENT_MASK:  geo_mask  = raw[MASK_W-1:0];
            CFG_DISK_LEN:      geo_len   = raw[LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random stall per cycle, plus a long hold-off whenever the
    // stimulus asks for one. The hold is counted here so the sender keeps
    // offering beats and the engine backs up into its input.
    // -----------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // reply checker: each accepted reply pairs with the oldest one due
    always @(posedge clk)
    begin : check_replies
        reply_t got, want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {read_data, status};
            if (replies_due.size() == 0)
                note_fault("reply with nothing due", '0, got);
            else
            begin
                want = replies_due.pop_front();
                if (got.data !== want.data || got.st !== want.st)
                    note_fault("reply mismatch", want, got);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned nd, sb, ln, nv, len_lim, r_hi, wd, pick, kind, a, b;
        logic [MASK_W-1:0] mk, low_bits;
        logic [LB_W-1:0]   lb;
        reply_t            typed_reply;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_NUM_DISKS;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_LOAD;
        disk_index    <= '0;
        word_index    <= '0;
        word_data     <= '0;
        logical_block <= '0;
        faults      = 0;
        holds_asked = 0;
        holds_done  = 0;
        cycles      = 0;
        tx_idle_pct = 13;
        rx_idle_pct = 50;
        geo_disks   = 5'd2;
        geo_strip   = 11'd1;
        geo_mask    = 16'hFFFF;
        geo_len     = 11'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
            begin
                if (plan[i].fn == FUNC_READ)
                    cover_read(plan[i].lb);
                typed_reply = '{data: plan[i].t_data, st: plan[i].t_st};
                send_item(plan[i].fn, plan[i].dsk, plan[i].wrd, plan[i].dat, plan[i].lb,
                          plan[i].typed, typed_reply);
            end
        end

        // random part: a fresh geometry per phase, idling pattern per third
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 4)
                0: begin tx_idle_pct = 13; rx_idle_pct = 50; end
                1: begin tx_idle_pct = 50; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase

            if (phase == 5)
            begin
                // the one large geometry: widest array, long strips, full disks
                nd = 16;
                sb = 1024;
                ln = 2047;
            end
            else
            begin
                nd   = ($urandom_range(99) < 85) ? $urandom_range(2, 16)
                                                 : $urandom_range(0, 31);
                pick = $urandom_range(99);
                if (pick < 80)      sb = $urandom_range(1, 8);
                else if (pick < 90) sb = $urandom_range(0, 2047);
                else                sb = $urandom_range(1) ? 1024 : 2047;
                pick = $urandom_range(99);
                if (pick < 85)      ln = $urandom_range(4, 64);
                else if (pick < 92) ln = 0;
                else                ln = $urandom_range(0, 2047);
            end

            // mask: all present, one gone, two gone, or anything
            nv       = (nd >= 2 && nd <= 16) ? nd : 16;
            low_bits = MASK_W'((32'h1 << nv) - 1);
            kind     = (phase == 5) ? 1 : $urandom_range(3);
            mk       = 16'hFFFF;
            case (kind)
                0: mk = 16'hFFFF;
                1: mk[$urandom_range(0, nv - 1)] = 1'b0;
                2:
                begin
                    a = $urandom_range(0, nv - 1);
                    b = (a + $urandom_range(1, nv - 1)) % nv;
                    mk[a] = 1'b0;
                    mk[b] = 1'b0;
                end
                default: mk = MASK_W'($urandom);
            endcase
            if (kind == 1 || kind == 2)
                mk = (mk & low_bits) | (MASK_W'($urandom) & ~low_bits);

            // stray upper bits on the write data must be dropped
            write_reg(CFG_NUM_DISKS,     CFG_W'(($urandom & 32'hFFE0) | nd));
            write_reg(CFG_STRIPE_BLOCKS, CFG_W'(($urandom & 32'hF800) | sb));
            write_reg(CFG_PRESENT_MASK,  mk);
            write_reg(CFG_DISK_LEN,      CFG_W'(($urandom & 32'hF800) | ln));

            len_lim = (geo_len > 1024) ? 1024 : geo_len;
            r_hi    = len_lim * (nv - 1) + geo_strip;
            if (r_hi > 16383)
                r_hi = 16383;

            // long receiver hold-off while beats keep coming
            if (phase == 0 || phase == 4)
                holds_asked++;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < 25)
                begin
                    wd = (len_lim != 0 && $urandom_range(99) < 70)
                         ? $urandom_range(0, len_lim - 1) : $urandom_range(0, 1023);
                    send_item(FUNC_LOAD, 4'($urandom_range(0, 15)), 10'(wd), $urandom,
                              14'($urandom), 0, '0);
                end
                else
                begin
                    // mostly blocks inside the disk length, so reads get past the
                    // range check; the rest spread over the whole block number
                    if (len_lim != 0 && r_hi != 0 && $urandom_range(99) < 75)
                        lb = LB_W'($urandom_range(0, r_hi));
                    else
                        lb = LB_W'($urandom_range(0, 16383));
                    cover_read(lb);
                    send_item(FUNC_READ, 4'($urandom_range(0, 15)), 10'($urandom),
                              $urandom, lb, 0, '0);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ raid5_read_with_reconstruct.f @@
+incdir+hdl
hdl/rwr_pkg.sv
hdl/rwr_div.sv
hdl/rwr_store.sv
hdl/raid5_read_with_reconstruct.sv
bench/raid5_read_with_reconstruct_test.sv
